// ===== rtl/som_mnu_pkg.sv =====
// Package with the shared types, constants and helpers of the moment neighbor update unit.
`default_nettype none
package som_mnu_pkg;

  localparam int UNITS_DEF  = 64;
  localparam int DIMS_DEF   = 16;
  localparam int ORDERS_DEF = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_WRITE  = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE   = 3'd0,
    REG_ORDERS = 3'd1,
    REG_DIMS   = 3'd2,
    REG_GAIN1  = 3'd3,
    REG_GAIN2  = 3'd4,
    REG_GAIN3  = 3'd5,
    REG_GAIN4  = 3'd6
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_SUM,
    S_DIVI,
    S_DIV,
    S_DIVE,
    S_POW,
    S_POWS,
    S_DIFF,
    S_UPD
  } state_t;

  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

  // Clamp to the signed 32-bit range; the top bit of the result flags a clamp.
  function automatic logic [32:0] sat32(input logic signed [47:0] v);
    logic [32:0] r;
    if (v > 48'sd2147483647) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -48'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/som_mnu_if.sv =====
// Valid/ready channel interfaces for commands and results.
`default_nettype none
interface som_mnu_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [5:0]         unit;
  logic [3:0]         dim;
  logic [1:0]         order;
  logic signed [15:0] sample;
  logic signed [31:0] entry_value;
  modport source (output valid, cmd, unit, dim, order, sample, entry_value, input ready);
  modport sink (input valid, cmd, unit, dim, order, sample, entry_value, output ready);
endinterface

interface som_mnu_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] read_value;
  logic               skipped;
  logic               saturated;
  modport source (output valid, read_value, skipped, saturated, input ready);
  modport sink (input valid, read_value, skipped, saturated, output ready);
endinterface
`default_nettype wire

// ===== rtl/som_mnu_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module som_mnu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic      [WIDTH-1:0]                 rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/som_moment_neighbor_update_unit.sv =====
// A load or write is done on acceptance; a read goes through S_READ. A moment update
// runs S_POW, S_POWS, S_DIFF and S_UPD for each dimension and order. A multinomial
// update sums the samples, then per dimension runs the restoring divider, one quotient
// bit per cycle, and S_DIFF and S_UPD; a zero sum skips the update after the summing.
// One word is in work at a time; a finished result waits in the output register.
// Synchronous reset, then a pass over all UNITS*DIMS*ORDERS entries zeroes the table
// before the first word is accepted; configuration writes are taken throughout.
`default_nettype none
module som_moment_neighbor_update_unit #(
  parameter int UNITS  = som_mnu_pkg::UNITS_DEF,
  parameter int DIMS   = som_mnu_pkg::DIMS_DEF,
  parameter int ORDERS = som_mnu_pkg::ORDERS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write_en,
  input  wire logic [som_mnu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [som_mnu_pkg::CFG_DATA_W-1:0] cfg_data,
  som_mnu_in_if.sink                             req,
  som_mnu_out_if.source                          rsp
);
  import som_mnu_pkg::*;

  localparam int DEPTH  = UNITS * DIMS * ORDERS;
  localparam int ADDR_W = $clog2(DEPTH > 1 ? DEPTH : 2);
  localparam int DIM_W  = $clog2(DIMS > 1 ? DIMS : 2);
  localparam int JW     = (DIM_W + 1 > 5) ? DIM_W + 1 : 5;
  localparam int OC_MAX = (ORDERS < 4) ? ORDERS : 4;

  // Configuration registers.
  logic        update_mode;
  logic [2:0]  order_count;
  logic [4:0]  dims_in_use;
  logic [15:0] gain [4];

  logic signed [15:0] store [DIMS];

  state_t state, state_next;

  logic [ADDR_W-1:0] clr;
  logic [5:0]        unit_r;
  logic [JW-1:0]     j;
  logic [2:0]        k;
  logic [JW-1:0]     nd;
  logic [2:0]        oc;
  logic signed [31:0] p;
  logic signed [47:0] pw_prod;
  logic signed [31:0] tgt;
  logic signed [31:0] e;
  logic signed [49:0] prod2;
  logic signed [20:0] s;
  logic [31:0]       num;
  logic [20:0]       den;
  logic [21:0]       rem;
  logic              neg;
  logic [5:0]        cnt;
  logic              sat_r;
  logic              rd_ok;

  logic              out_valid;
  logic signed [31:0] out_rv;
  logic              out_skip;
  logic              out_sat;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [31:0]       mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [31:0]       mem_rdata;

  logic              accept;
  logic              unit_ok, dim_ok, ord_ok;
  logic [ADDR_W-1:0] in_addr, upd_addr;
  logic [JW-1:0]     nd_cfg;
  logic [2:0]        oc_cfg;
  logic signed [15:0] x_cur;
  logic [32:0]       pow_sat, upd_sat, div_sat;
  logic signed [47:0] pw_rnd;
  logic signed [49:0] prod2_rnd;
  logic signed [47:0] upd_sum;
  logic signed [32:0] diff;
  logic signed [32:0] q_signed;
  logic [21:0]       trial;
  logic [15:0]       x_mag;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE) && (!out_valid || rsp.ready);

  assign rsp.valid      = out_valid;
  assign rsp.read_value = out_rv;
  assign rsp.skipped    = out_skip;
  assign rsp.saturated  = out_sat;

  assign unit_ok = 32'(req.unit) < UNITS;
  assign dim_ok  = 32'(req.dim) < DIMS;
  assign ord_ok  = 32'(req.order) < ORDERS;

  assign in_addr  = ADDR_W'(req.unit) * ADDR_W'(DIMS * ORDERS)
                  + ADDR_W'(req.dim) * ADDR_W'(ORDERS) + ADDR_W'(req.order);
  assign upd_addr = ADDR_W'(unit_r) * ADDR_W'(DIMS * ORDERS)
                  + ADDR_W'(j) * ADDR_W'(ORDERS) + ADDR_W'(k);

  assign nd_cfg = (32'(dims_in_use) > DIMS) ? JW'(DIMS) : JW'(dims_in_use);
  assign oc_cfg = (32'(order_count) > OC_MAX) ? 3'(OC_MAX) : order_count;

  assign x_cur = store[j[DIM_W-1:0]];
  assign x_mag = x_cur[15] ? 16'(-x_cur) : 16'(x_cur);

  assign pw_rnd  = (pw_prod + 48'sd128) >>> 8;
  assign pow_sat = sat32(pw_rnd);

  // The entry is taken straight from the table read port, valid in S_DIFF.
  assign diff      = 33'(tgt) - 33'($signed(mem_rdata));
  assign prod2_rnd = (prod2 + 50'sd32768) >>> 16;
  assign upd_sum   = 48'(e) + 48'(prod2_rnd);
  assign upd_sat   = sat32(upd_sum);

  assign q_signed = neg ? -$signed({1'b0, num}) : $signed({1'b0, num});
  assign div_sat  = sat32(48'(q_signed));
  assign trial    = {rem[20:0], num[31]};

  som_mnu_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and table port control.
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = upd_addr;
    mem_wdata  = upd_sat[31:0];
    mem_raddr  = upd_addr;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr;
        mem_wdata = '0;
        if (clr == ADDR_W'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        mem_raddr = in_addr;
        if (accept) begin
          unique case (cmd_t'(req.cmd))
            CMD_READ: state_next = S_READ;
            CMD_WRITE: begin
              mem_we    = unit_ok && dim_ok && ord_ok;
              mem_waddr = in_addr;
              mem_wdata = req.entry_value;
            end
            CMD_UPDATE: begin
              if (unit_ok) begin
                if (update_mode) begin
                  state_next = S_SUM;
                end else if (nd_cfg != '0 && oc_cfg != '0) begin
                  state_next = S_POW;
                end
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_READ: state_next = S_IDLE;
      S_SUM: begin
        if (j >= nd) begin
          state_next = (s == '0) ? S_IDLE : S_DIVI;
        end
      end
      S_DIVI: state_next = S_DIV;
      S_DIV: begin
        if (cnt == 6'd1) begin
          state_next = S_DIVE;
        end
      end
      S_DIVE: state_next = S_DIFF;
      S_POW: state_next = S_POWS;
      S_POWS: state_next = S_DIFF;
      S_DIFF: state_next = S_UPD;
      S_UPD: begin
        mem_we = 1'b1;
        if (update_mode) begin
          state_next = (j + 1'b1 < nd) ? S_DIVI : S_IDLE;
        end else if (k + 3'd1 < oc || j + 1'b1 < nd) begin
          state_next = S_POW;
        end else begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Configuration registers and sample store.
  always_ff @(posedge clk) begin
    if (rst) begin
      update_mode <= 1'b0;
      order_count <= 3'd1;
      dims_in_use <= 5'd16;
      for (int i = 0; i < 4; i++) begin
        gain[i] <= '0;
      end
      for (int i = 0; i < DIMS; i++) begin
        store[i] <= '0;
      end
    end else begin
      if (cfg_write_en) begin
        case (cfg_reg_t'(cfg_index))
          REG_MODE:   update_mode <= cfg_data[0];
          REG_ORDERS: order_count <= cfg_data[2:0];
          REG_DIMS:   dims_in_use <= cfg_data[4:0];
          REG_GAIN1:  gain[0] <= cfg_data;
          REG_GAIN2:  gain[1] <= cfg_data;
          REG_GAIN3:  gain[2] <= cfg_data;
          REG_GAIN4:  gain[3] <= cfg_data;
          default: ;
        endcase
      end
      if (accept && cmd_t'(req.cmd) == CMD_LOAD && dim_ok) begin
        store[DIM_W'(req.dim)] <= req.sample;
      end
    end
  end

  // Sequencer datapath and output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: clr <= clr + 1'b1;
        S_IDLE: begin
          if (accept) begin
            unit_r <= req.unit;
            j      <= '0;
            k      <= '0;
            nd     <= nd_cfg;
            oc     <= oc_cfg;
            p      <= ONE_Q16;
            s      <= '0;
            sat_r  <= 1'b0;
            rd_ok  <= unit_ok && dim_ok && ord_ok;
            if (state_next == S_IDLE) begin
              out_valid <= 1'b1;
              out_rv    <= '0;
              out_skip  <= 1'b0;
              out_sat   <= 1'b0;
            end
          end
        end
        S_READ: begin
          out_valid <= 1'b1;
          out_rv    <= rd_ok ? mem_rdata : '0;
          out_skip  <= 1'b0;
          out_sat   <= 1'b0;
        end
        S_SUM: begin
          if (j < nd) begin
            s <= s + 21'(x_cur);
            j <= j + 1'b1;
          end else begin
            j <= '0;
            if (s == '0) begin
              out_valid <= 1'b1;
              out_rv    <= '0;
              out_skip  <= 1'b1;
              out_sat   <= 1'b0;
            end
          end
        end
        S_DIVI: begin
          num <= {x_mag, 16'h0000};
          den <= s[20] ? 21'(-s) : 21'(s);
          neg <= x_cur[15] ^ s[20];
          rem <= '0;
          cnt <= 6'd32;
        end
        S_DIV: begin
          // Restoring division, one quotient bit per cycle.
          if (trial >= {1'b0, den}) begin
            rem <= trial - {1'b0, den};
            num <= {num[30:0], 1'b1};
          end else begin
            rem <= trial;
            num <= {num[30:0], 1'b0};
          end
          cnt <= cnt - 6'd1;
        end
        S_DIVE: begin
          tgt   <= div_sat[31:0];
          sat_r <= sat_r | div_sat[32];
        end
        S_POW: pw_prod <= p * x_cur;
        S_POWS: begin
          p     <= pow_sat[31:0];
          tgt   <= pow_sat[31:0];
          sat_r <= sat_r | pow_sat[32];
        end
        S_DIFF: begin
          e     <= mem_rdata;
          prod2 <= diff * $signed({1'b0, gain[k[1:0]]});
        end
        S_UPD: begin
          if (state_next == S_IDLE) begin
            out_valid <= 1'b1;
            out_rv    <= '0;
            out_skip  <= 1'b0;
            out_sat   <= sat_r | upd_sat[32];
          end else begin
            sat_r <= sat_r | upd_sat[32];
          end
          if (update_mode) begin
            j <= j + 1'b1;
          end else if (k + 3'd1 < oc) begin
            k <= k + 3'd1;
          end else begin
            k <= '0;
            j <= j + 1'b1;
            p <= ONE_Q16;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire
